// ===== hw/rtl/topic_filter_matcher_core_defines.svh =====
// assertion macros used by the checker file of the topic filter matcher
`ifndef TOPIC_FILTER_MATCHER_CORE_DEFINES_SVH
`define TOPIC_FILTER_MATCHER_CORE_DEFINES_SVH

// same-cycle implication
`define TFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tfm_pkg.sv =====
// shared types and constants of the topic filter matcher
package tfm_pkg;

  localparam int FILTER_BYTES_DEF = 64;
  localparam int POS_W            = 6;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_TOPIC = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    logic [7:0]       char_byte;
    logic             last;
  } tfm_in_t;

  typedef struct packed {
    logic matched;
  } tfm_out_t;

endpackage

// ===== hw/rtl/tfm_stream_if.sv =====
// valid/ready stream channel carrying one word of a given payload type
interface tfm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/topic_filter_matcher_core.sv =====
// topic filter matcher: one stored filter, topic bytes matched one word per cycle while ready is high
//
// ingress carries one byte per word: op load writes a filter byte at position
// (last sets the filter length), op topic streams a topic byte. egress carries
// one word per topic, sent after its last byte: matched is 1 when the whole
// topic fits the stored filter ('+' spans one level, a final '#' the rest).
// throughput: one word per cycle while ready is high. a topic '/' that meets
// '+' bytes holds ready low while the matcher steps past each '+', since each
// filter byte needs its own read of the filter memory (one read port, registered read data).
// the result goes to the output register when the end check finishes: as the
// last topic byte is taken, or later when that byte moved the filter cursor or
// the end check then steps over a '+'; ready stays low meanwhile.
// reset clears the matcher and the filter length; filter bytes are kept in
// memory, unwritten bytes are undefined. when egress stalls, one more result
// fits in a skid register; while that is full, ingress ready is low.
// a filter load resets the matching cursor; a load beyond the store is dropped.
module topic_filter_matcher_core
  import tfm_pkg::*;
#(
  parameter int FILTER_BYTES = FILTER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tfm_stream_if.sink   ingress,
  tfm_stream_if.source egress
);

  localparam int AW = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
  localparam int CW = $clog2(FILTER_BYTES + 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LEVEL,
    ST_YES,
    ST_NO
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BYTE,
    PH_END
  } phase_t;

  typedef struct packed {
    status_t       st;
    logic          sk;
    logic [CW-1:0] cur;
  } mstate_t;

  typedef struct packed {
    mstate_t s;
    logic    done;
  } step_t;

  function automatic logic hash_final(logic [7:0] f, logic [CW-1:0] cur,
                                      logic [CW-1:0] len);
    return (f == CH_HASH) && ((cur + 1'b1) == len);
  endfunction

  // one topic byte against the filter byte at the cursor; stops early when
  // the cursor moves and the next filter byte is needed for this same byte
  function automatic step_t byte_step(mstate_t s, logic [7:0] f, logic [7:0] c,
                                      logic [CW-1:0] len);
    step_t r;
    logic  go;
    logic  at_end;
    r      = '{s: s, done: 1'b1};
    go     = 1'b1;
    at_end = (s.cur >= len);
    if (s.st == ST_YES || s.st == ST_NO) begin
      go = 1'b0;
    end
    if (go && s.sk) begin
      if (c != CH_SLASH) begin
        go = 1'b0;
      end else begin
        r.s.sk = 1'b0;
        r.s.st = ST_LEVEL;
      end
    end
    if (go && r.s.st == ST_LEVEL) begin
      priority if (at_end) begin
        r.s.st = ST_NO;
        go     = 1'b0;
      end else if (f == CH_SLASH && c == CH_SLASH) begin
        r.s.cur = s.cur + 1'b1;
        r.s.st  = ST_RUN;
        go      = 1'b0;
      end else begin
        r.s.st = ST_RUN;
      end
    end
    if (go) begin
      priority if (at_end) begin
        r.s.st = ST_NO;
      end else if (f == CH_HASH) begin
        r.s.st = hash_final(f, s.cur, len) ? ST_YES : ST_NO;
      end else if (f == CH_PLUS) begin
        r.s.cur = s.cur + 1'b1;
        if (c == CH_SLASH) begin
          // empty level: separator check continues at the next filter byte
          r.s.st   = ST_LEVEL;
          r.done   = 1'b0;
        end else begin
          r.s.sk = 1'b1;
        end
      end else if (f != c) begin
        r.s.st = ST_NO;
      end else begin
        r.s.cur = s.cur + 1'b1;
        r.s.st  = ST_LEVEL;
      end
    end
    return r;
  endfunction

  // end of topic; fok says whether f belongs to the cursor handed in
  function automatic step_t end_step(mstate_t s, logic [7:0] f, logic fok,
                                     logic [CW-1:0] len);
    step_t r;
    logic  at_end;
    r      = '{s: s, done: 1'b1};
    at_end = (s.cur >= len);
    if (s.st == ST_RUN || s.st == ST_LEVEL) begin
      if (s.sk) begin
        r.s.sk = 1'b0;
        r.s.st = ST_LEVEL;
      end
      priority if (at_end) begin
        r.s.st = ST_YES;
      end else if (!fok) begin
        r.done = 1'b0;
      end else if (r.s.st == ST_LEVEL || f == CH_HASH) begin
        r.s.st = hash_final(f, s.cur, len) ? ST_YES : ST_NO;
      end else if (f == CH_PLUS) begin
        r.s.cur = s.cur + 1'b1;
        r.s.st  = ST_LEVEL;
        if ((s.cur + 1'b1) >= len) begin
          r.s.st = ST_YES;
        end else begin
          r.done = 1'b0;
        end
      end else begin
        r.s.st = ST_NO;
      end
    end
    return r;
  endfunction

  logic [7:0] filter_mem [FILTER_BYTES];

  phase_t        phase, phase_next;
  status_t       status, status_next;
  logic          skip, skip_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [CW-1:0] length, length_next;
  logic [7:0]    cbyte, cbyte_next;
  logic          last_pend, last_pend_next;
  logic [7:0]    rdata;
  logic          out_valid, out_valid_next;
  logic          out_matched, out_matched_next;
  logic          skid_valid, skid_valid_next;
  logic          skid_matched, skid_matched_next;

  logic                accept, is_topic, is_load, pos_ok, mem_we, fwd;
  logic                run_byte, last_sel, want_end, end_fok;
  logic                res_valid, res_matched, out_take;
  logic [7:0]          c_sel;
  logic [POS_W+AW-1:0] pos_ext;
  logic [AW-1:0]       waddr, raddr;
  mstate_t             cur_s, end_in;
  step_t               bs, es;

  assign ingress.ready          = (phase == PH_IDLE) && !skid_valid;
  assign egress.valid           = out_valid;
  assign egress.payload.matched = out_matched;

  assign accept   = ingress.valid && ingress.ready;
  assign is_topic = accept && (ingress.payload.op == OP_TOPIC);
  assign is_load  = accept && (ingress.payload.op == OP_LOAD);
  assign pos_ok   = int'(ingress.payload.position) < FILTER_BYTES;
  assign pos_ext  = {{AW{1'b0}}, ingress.payload.position};
  assign waddr    = pos_ext[AW-1:0];
  assign mem_we   = is_load && pos_ok;
  assign out_take = out_valid && egress.ready;

  always_comb begin
    cur_s.st  = status;
    cur_s.sk  = skip;
    cur_s.cur = cursor;

    run_byte = (phase == PH_BYTE) || is_topic;
    c_sel    = (phase == PH_BYTE) ? cbyte : ingress.payload.char_byte;
    last_sel = (phase == PH_BYTE) ? last_pend : ingress.payload.last;

    bs = byte_step(cur_s, rdata, c_sel, length);

    // the end check can follow in the same cycle while the cursor stays put
    end_in   = run_byte ? bs.s : cur_s;
    end_fok  = run_byte ? (bs.s.cur == cursor) : 1'b1;
    es       = end_step(end_in, rdata, end_fok, length);
    want_end = (phase == PH_END) || (run_byte && bs.done && last_sel);

    phase_next     = phase;
    status_next    = status;
    skip_next      = skip;
    cursor_next    = cursor;
    length_next    = length;
    cbyte_next     = cbyte;
    last_pend_next = last_pend;
    res_valid      = 1'b0;
    res_matched    = (es.s.st == ST_YES);

    priority if (mem_we) begin
      phase_next  = PH_IDLE;
      status_next = ST_RUN;
      skip_next   = 1'b0;
      cursor_next = '0;
      if (ingress.payload.last) begin
        length_next = CW'(pos_ext + 1'b1);
      end
    end else if (run_byte && !bs.done) begin
      phase_next     = PH_BYTE;
      status_next    = bs.s.st;
      skip_next      = bs.s.sk;
      cursor_next    = bs.s.cur;
      cbyte_next     = c_sel;
      last_pend_next = last_sel;
    end else if (want_end) begin
      if (es.done) begin
        res_valid   = 1'b1;
        phase_next  = PH_IDLE;
        status_next = ST_RUN;
        skip_next   = 1'b0;
        cursor_next = '0;
      end else begin
        phase_next  = PH_END;
        status_next = es.s.st;
        skip_next   = es.s.sk;
        cursor_next = es.s.cur;
      end
    end else if (run_byte) begin
      phase_next  = PH_IDLE;
      status_next = bs.s.st;
      skip_next   = bs.s.sk;
      cursor_next = bs.s.cur;
    end else begin
      phase_next = phase;
    end

    // output register with one skid word behind it
    out_valid_next    = out_valid;
    out_matched_next  = out_matched;
    skid_valid_next   = skid_valid;
    skid_matched_next = skid_matched;
    if (out_take || !out_valid) begin
      out_valid_next   = skid_valid || res_valid;
      out_matched_next = skid_valid ? skid_matched : res_matched;
      skid_valid_next  = 1'b0;
    end else if (res_valid) begin
      skid_valid_next   = 1'b1;
      skid_matched_next = res_matched;
    end
  end

  // read address always follows the cursor so rdata holds its filter byte
  assign raddr = rst ? '0 : cursor_next[AW-1:0];
  assign fwd   = mem_we && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      filter_mem[waddr] <= ingress.payload.char_byte;
    end
    rdata <= fwd ? ingress.payload.char_byte : filter_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      status     <= ST_RUN;
      skip       <= 1'b0;
      cursor     <= '0;
      length     <= '0;
      last_pend  <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      status     <= status_next;
      skip       <= skip_next;
      cursor     <= cursor_next;
      length     <= length_next;
      last_pend  <= last_pend_next;
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cbyte        <= cbyte_next;
    out_matched  <= out_matched_next;
    skid_matched <= skid_matched_next;
  end

endmodule

// ===== hw/rtl/tfm_checker.sv =====
// port-level checker for the topic filter matcher, bound to the top level
`include "topic_filter_matcher_core_defines.svh"

module tfm_checker
  import tfm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input op_t  in_op,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);

  // results owed: topic ends taken minus result words delivered
  logic [1:0] owed;
  logic       topic_end, out_take;

  assign topic_end = in_valid && in_ready && (in_op == OP_TOPIC) && in_last;
  assign out_take  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + {1'b0, topic_end} - {1'b0, out_take};
    end
  end

  `TFM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_matched), "result word dropped or changed while stalled")
  `TFM_ASSERT_NOW(a_out_owed, clk, rst, out_valid, owed != 2'd0, "result word without a topic end")
  `TFM_ASSERT_NOW(a_full_stall, clk, rst, owed == 2'd2, !in_ready, "input taken with two results waiting")
  `TFM_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !out_valid, "result word valid after reset")

endmodule

bind topic_filter_matcher_core tfm_checker u_tfm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (ingress.valid),
  .in_ready   (ingress.ready),
  .in_op      (ingress.payload.op),
  .in_last    (ingress.payload.last),
  .out_valid  (egress.valid),
  .out_ready  (egress.ready),
  .out_matched(egress.payload.matched)
);
